/* src/itp_pkg.sv */
// Shared types, character codes and operator helpers for the infix to postfix converter.
package itp_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPACE,
      ST_DECIDE,
      ST_POP_OP,
      ST_POP_SP,
      ST_MARK
   } state_type;

   // Operator codes held on the stack.
   typedef logic [2:0] op_code_type;

   localparam op_code_type OP_ADD  = 3'd0;
   localparam op_code_type OP_SUB  = 3'd1;
   localparam op_code_type OP_MUL  = 3'd2;
   localparam op_code_type OP_DIV  = 3'd3;
   localparam op_code_type OP_POW  = 3'd4;
   localparam op_code_type OP_LPAR = 3'd5;

   // Operator ranks.
   typedef logic [1:0] rank_type;

   localparam rank_type RANK_ADD = 2'd0;
   localparam rank_type RANK_MUL = 2'd1;
   localparam rank_type RANK_POW = 2'd2;

   // ASCII codes.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Command from the sequencer to the operator stack.
   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      op_code_type code;
   } stack_cmd_type;

   // Status of the operator stack.
   typedef struct packed {
      logic        empty;
      logic        full;
      op_code_type top;
   } stack_sts_type;

   // One result produced by the sequencer.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       byte_valid;
      logic       last;
      logic       error;
   } emit_type;

   // True for characters that belong to a number.
   function automatic logic is_num_char(input logic [7:0] ch);
      is_num_char = ((ch >= CH_ZERO) && (ch <= CH_NINE)) || (ch == CH_DOT);
   endfunction

   // Text of a stacked operator.
   function automatic logic [7:0] op_text(input op_code_type code);
      logic [7:0] txt;
      case (code)
         OP_ADD:  txt = CH_PLUS;
         OP_SUB:  txt = CH_MINUS;
         OP_MUL:  txt = CH_STAR;
         OP_DIV:  txt = CH_SLASH;
         OP_POW:  txt = CH_CARET;
         OP_LPAR: txt = CH_LPAR;
         default: txt = CH_QUERY;
      endcase
      op_text = txt;
   endfunction

   // Precedence rank of a stacked operator.
   function automatic rank_type op_rank(input op_code_type code);
      rank_type r;
      case (code)
         OP_ADD, OP_SUB: r = RANK_ADD;
         OP_MUL, OP_DIV: r = RANK_MUL;
         default:        r = RANK_POW;
      endcase
      op_rank = r;
   endfunction

endpackage

/* src/itp_stack.sv */
// Operator stack: a small memory with a fill count and a registered top entry.
module itp_stack #(
   parameter int unsigned STACK_DEPTH = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  itp_pkg::stack_cmd_type cmd,
   output itp_pkg::stack_sts_type sts
);
   import itp_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   op_code_type     mem [STACK_DEPTH];
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   op_code_type     top_ff;
   logic [CW-1:0]   rd_count;
   logic [CW-1:0]   rd_idx_wide;
   logic [AW-1:0]   rd_idx;
   logic [AW-1:0]   wr_idx;

   // Fill count update.
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // The read looks at the entry that is top after this cycle's pop.
   assign rd_count    = cmd.pop ? (count_ff - CW'(1)) : count_ff;
   assign rd_idx_wide = rd_count - CW'(1);
   assign rd_idx      = rd_idx_wide[AW-1:0];
   assign wr_idx      = count_ff[AW-1:0];

   // Memory write port and registered read port; a push bypasses into the top.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_idx] <= cmd.code;
         top_ff      <= cmd.code;
      end else if (rd_count != '0) begin
         top_ff <= mem[rd_idx];
      end
   end

   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == CW'(STACK_DEPTH));
   assign sts.top   = top_ff;

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !sts.full)
      else $error("push onto a full operator stack");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !sts.empty)
      else $error("pop from an empty operator stack");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("operator stack count out of range");

   a_push_top: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (top_ff == $past(cmd.code)))
      else $error("pushed operator not on top");
`endif

endmodule

/* src/itp_ctrl.sv */
// Sequencer: decodes one character and steps through its pops, pushes and emitted bytes.
module itp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tuser,
   input  logic                   out_free,
   output itp_pkg::emit_type      emit,
   output itp_pkg::stack_cmd_type stk_cmd,
   input  itp_pkg::stack_sts_type stk_sts
);
   import itp_pkg::*;

   state_type   state_ff;
   state_type   state_in;
   logic [7:0]  chr_ff;
   logic [7:0]  chr_in;
   logic        act_ff;
   logic        act_in;
   logic        in_num_ff;
   logic        in_num_in;
   logic        err_ff;
   logic        err_in;

   logic        is_num;
   logic        is_addsub;
   logic        is_muldiv;
   logic        is_pow;
   logic        is_lpar;
   logic        is_rpar;
   logic        pop_cand;
   logic        more_pop;
   op_code_type push_code;
   logic        push_req;

   // Character decode of the held item.
   always_comb begin
      is_num    = is_num_char(chr_ff);
      is_addsub = chr_ff inside {CH_PLUS, CH_MINUS};
      is_muldiv = chr_ff inside {CH_STAR, CH_SLASH};
      is_pow    = (chr_ff == CH_CARET);
      is_lpar   = (chr_ff == CH_LPAR);
      is_rpar   = (chr_ff == CH_RPAR);
   end

   // Rank compare against the stack top decides whether another pop follows.
   always_comb begin
      pop_cand = !stk_sts.empty && (stk_sts.top != OP_LPAR);
      if (act_ff) begin
         more_pop = !stk_sts.empty;
      end else if (is_addsub || is_rpar) begin
         more_pop = pop_cand;
      end else if (is_muldiv) begin
         more_pop = pop_cand && (op_rank(stk_sts.top) >= RANK_MUL);
      end else begin
         more_pop = 1'b0;
      end
   end

   // Code pushed by the held character.
   always_comb begin
      push_req = is_addsub || is_muldiv || is_pow || is_lpar;
      if (chr_ff == CH_PLUS) begin
         push_code = OP_ADD;
      end else if (chr_ff == CH_MINUS) begin
         push_code = OP_SUB;
      end else if (chr_ff == CH_STAR) begin
         push_code = OP_MUL;
      end else if (chr_ff == CH_SLASH) begin
         push_code = OP_DIV;
      end else if (is_pow) begin
         push_code = OP_POW;
      end else begin
         push_code = OP_LPAR;
      end
   end

   // Next state, emitted results and stack commands.
   always_comb begin
      state_in     = state_ff;
      chr_in       = chr_ff;
      act_in       = act_ff;
      in_num_in    = in_num_ff;
      err_in       = err_ff;
      req_tready   = 1'b0;
      emit         = '0;
      stk_cmd      = '0;
      stk_cmd.code = push_code;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               chr_in = req_tdata;
               act_in = req_tuser;
               if (in_num_ff && (req_tuser || !is_num_char(req_tdata))) begin
                  state_in = ST_SPACE;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_SPACE: begin
            if (out_free) begin
               emit.valid      = 1'b1;
               emit.data       = CH_SPACE;
               emit.byte_valid = 1'b1;
               emit.last       = !act_ff && !more_pop;
               in_num_in       = 1'b0;
               state_in        = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (act_ff) begin
               state_in = stk_sts.empty ? ST_MARK : ST_POP_OP;
            end else if (is_num) begin
               if (out_free) begin
                  emit.valid      = 1'b1;
                  emit.data       = chr_ff;
                  emit.byte_valid = 1'b1;
                  emit.last       = 1'b1;
                  in_num_in       = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (more_pop) begin
               state_in = ST_POP_OP;
            end else begin
               // Push the operator, or discard the matching parenthesis.
               if (push_req) begin
                  if (stk_sts.full) begin
                     err_in = 1'b1;
                  end else begin
                     stk_cmd.push = 1'b1;
                  end
               end else if (is_rpar) begin
                  if (stk_sts.empty) begin
                     err_in = 1'b1;
                  end else begin
                     stk_cmd.pop = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_POP_OP: begin
            if (out_free) begin
               emit.valid      = 1'b1;
               emit.data       = op_text(stk_sts.top);
               emit.byte_valid = 1'b1;
               stk_cmd.pop     = 1'b1;
               state_in        = ST_POP_SP;
            end
         end
         ST_POP_SP: begin
            if (out_free) begin
               emit.valid      = 1'b1;
               emit.data       = CH_SPACE;
               emit.byte_valid = 1'b1;
               emit.last       = !act_ff && !more_pop;
               state_in        = ST_DECIDE;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               emit.valid    = 1'b1;
               emit.data     = CH_NUL;
               emit.last     = 1'b1;
               emit.error    = err_ff;
               err_in        = 1'b0;
               stk_cmd.clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         in_num_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_num_ff <= in_num_in;
         err_ff    <= err_in;
      end
   end

   // Held item.
   always_ff @(posedge clock) begin
      chr_ff <= chr_in;
      act_ff <= act_in;
   end

endmodule

/* src/infix_to_postfix_converter.sv */
// Top level of the infix to postfix converter: sequencer, operator stack and result register.
//
//   Channel | Direction | tdata          | tuser                   | tlast
//   req_    | in        | [7:0] char_in  | [0] action              | -
//   rsp_    | out       | [7:0] out_byte | [0] byte_valid, [1] error | last of item
//
// A digit or '.' passes through the idle and decide steps; so does an ignored character
// or a push, with a space step first when it ends a number. Each popped operator adds
// the decide step and one step for each of its two bytes, paced by the stack's
// registered read port. An end item adds a step for its marker.
// Reset is synchronous and active high; the stack memory needs no clearing.
// A stalled result holds the sequencer in place until the transfer completes.
module infix_to_postfix_converter #(
   parameter int unsigned STACK_DEPTH = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tuser,   // [0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] error
   output logic       rsp_tlast
);
   import itp_pkg::*;

   emit_type      emit;
   stack_cmd_type stk_cmd;
   stack_sts_type stk_sts;
   logic          out_free;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;
   logic [1:0]    rsp_user_ff;
   logic          rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   itp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .emit       (emit),
      .stk_cmd    (stk_cmd),
      .stk_sts    (stk_sts)
   );

   itp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .sts   (stk_sts)
   );

   // Result register; loads whenever it is empty or its transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit.valid) begin
         rsp_data_ff <= emit.data;
         rsp_user_ff <= {emit.error, emit.byte_valid};
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* sim/tb_infix_to_postfix_converter.sv */
// Testbench for the infix to postfix converter: random expressions checked against a predictor.
`timescale 1ns / 100ps

module tb_infix_to_postfix_converter;
   import itp_pkg::*;

   localparam int unsigned STACK_LIMIT = 31;
   localparam int unsigned RANDOM_ITEMS = 500;

   // Text of each stacked operator code, in code order.
   localparam logic [7:0] OP_GLYPH [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                           CH_CARET, CH_LPAR, CH_QUERY, CH_QUERY};
   // Binary operators as they appear in the expression text.
   localparam logic [7:0] BIN_OPS [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

   // One expected result byte or end marker.
   typedef struct packed {
      logic [7:0] text;
      logic       text_valid;
      logic       item_last;
      logic       err;
   } postfix_byte_type;

   // One pending expression character or end of expression.
   typedef struct {
      logic       is_end;
      logic [7:0] ch;
      bit         settle;
   } char_item_type;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_BEAT
   } rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_in
   logic       req_tuser = 1'b0;    // [0] action
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [1:0] rsp_tuser;           // [0] byte_valid, [1] error
   logic       rsp_tlast;

   char_item_type    char_backlog [$];
   postfix_byte_type postfix_due [$];
   postfix_byte_type step_bytes [$];
   int unsigned      faults = 0;
   int unsigned      counted = 0;
   bit               settle_next = 0;

   // Predictor state.
   op_code_type op_stack [STACK_LIMIT];
   int unsigned op_depth = 0;
   bit          number_open = 0;
   bit          paren_error = 0;

   // Sender and receiver pacing.
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned rx_left = 0;
   int unsigned beat = 0;
   rx_mode_type rx_mode = RX_OPEN;

   infix_to_postfix_converter #(
      .STACK_DEPTH(STACK_LIMIT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Appends one byte of postfix text to the results of the current step.
   function automatic void put_text(input logic [7:0] b);
      postfix_byte_type r;
      r.text = b;
      r.text_valid = 1'b1;
      r.item_last = 1'b0;
      r.err = 1'b0;
      step_bytes.push_back(r);
   endfunction

   // Pops the top operator and emits it followed by a space.
   function automatic void pop_to_text();
      put_text(OP_GLYPH[op_stack[op_depth - 1]]);
      put_text(CH_SPACE);
      op_depth--;
   endfunction

   // A push onto a full stack is lost and flags the expression.
   function automatic void push_op(input op_code_type code);
      if (op_depth >= STACK_LIMIT) begin
         paren_error = 1;
      end else begin
         op_stack[op_depth] = code;
         op_depth++;
      end
   endfunction

   // Pops operators of at least the given rank; a '(' stops the scan.
   function automatic void pop_ranked(input rank_type floor_rank);
      rank_type r;
      bit       done;
      done = 0;
      r = RANK_ADD;
      while (!done && op_depth > 0) begin
         case (op_stack[op_depth - 1])
            OP_ADD, OP_SUB: r = RANK_ADD;
            OP_MUL, OP_DIV: r = RANK_MUL;
            OP_POW:         r = RANK_POW;
            default:        done = 1;
         endcase
         if (!done && r >= floor_rank) begin
            pop_to_text();
         end else begin
            done = 1;
         end
      end
   endfunction

   // Works out the postfix results of one accepted item and queues them.
   function automatic void predict_postfix(input logic is_end, input logic [7:0] ch);
      postfix_byte_type marker;
      step_bytes = {};
      if (is_end) begin
         if (number_open) put_text(CH_SPACE);
         number_open = 0;
         while (op_depth > 0) pop_to_text();
         marker.text = CH_NUL;
         marker.text_valid = 1'b0;
         marker.item_last = 1'b0;
         marker.err = paren_error;
         step_bytes.push_back(marker);
         paren_error = 0;
      end else if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_DOT) begin
         put_text(ch);
         number_open = 1;
      end else begin
         // Anything else closes a number in progress.
         if (number_open) put_text(CH_SPACE);
         number_open = 0;
         case (ch)
            CH_PLUS, CH_MINUS: begin
               pop_ranked(RANK_ADD);
               push_op((ch == CH_PLUS) ? OP_ADD : OP_SUB);
            end
            CH_STAR, CH_SLASH: begin
               pop_ranked(RANK_MUL);
               push_op((ch == CH_STAR) ? OP_MUL : OP_DIV);
            end
            CH_CARET: push_op(OP_POW);
            CH_LPAR:  push_op(OP_LPAR);
            CH_RPAR: begin
               while (op_depth > 0 && op_stack[op_depth - 1] != OP_LPAR) pop_to_text();
               if (op_depth == 0) begin
                  paren_error = 1;
               end else begin
                  op_depth--;
               end
            end
            default: ;
         endcase
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].item_last = 1'b1;
      foreach (step_bytes[k]) postfix_due.push_back(step_bytes[k]);
   endfunction

   // Stimulus building.
   function automatic void queue_char(input logic is_end, input logic [7:0] ch);
      char_item_type it;
      it.is_end = is_end;
      it.ch = ch;
      it.settle = settle_next;
      settle_next = 0;
      char_backlog.push_back(it);
      if (is_end || (ch >= CH_ZERO && ch <= CH_NINE) ||
          ch inside {CH_DOT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_LPAR, CH_RPAR})
         counted++;
   endfunction

   function automatic void queue_text(input string s);
      for (int k = 0; k < s.len(); k++) queue_char(1'b0, s[k]);
   endfunction

   function automatic void queue_number();
      int unsigned n;
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
         if (k > 0 && $urandom_range(0, 5) == 0) queue_char(1'b0, CH_DOT);
         queue_char(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   function automatic void queue_operand(input int nest);
      if ($urandom_range(0, 7) == 0) queue_char(1'b0, CH_SPACE);
      if (nest < 4 && $urandom_range(0, 3) == 0) begin
         queue_char(1'b0, CH_LPAR);
         queue_expr(nest + 1);
         queue_char(1'b0, CH_RPAR);
      end else begin
         queue_number();
      end
   endfunction

   // Well-formed expression with random numbers, operators and nesting.
   function automatic void queue_expr(input int nest);
      int unsigned terms;
      terms = $urandom_range(1, 4);
      queue_operand(nest);
      for (int k = 1; k < terms; k++) begin
         queue_char(1'b0, BIN_OPS[$urandom_range(0, 4)]);
         queue_operand(nest);
      end
   endfunction

   function automatic void build_random();
      int unsigned kind;
      int unsigned n;
      logic [7:0] tokens [12];
      tokens = '{CH_ZERO, CH_NINE, CH_DOT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                 CH_CARET, CH_LPAR, CH_RPAR, CH_SPACE, 8'h37};
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         settle_next = settle_next || ($urandom_range(0, 19) == 0);
         kind = $urandom_range(0, 19);
         if (kind < 13) begin
            queue_expr(0);
         end else if (kind < 15) begin
            // Deep nesting around the stack limit, overflowing it at times.
            n = $urandom_range(STACK_LIMIT - 3, STACK_LIMIT + 3);
            for (int k = 0; k < n; k++) begin
               queue_char(1'b0, $urandom_range(0, 1) ? CH_LPAR : CH_CARET);
               if ($urandom_range(0, 3) == 0) queue_number();
            end
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) queue_char(1'b0, CH_RPAR);
         end else if (kind < 18) begin
            // Broken sequences: tokens in random order, parentheses not kept balanced.
            n = $urandom_range(3, 20);
            for (int k = 0; k < n; k++) queue_char(1'b0, tokens[$urandom_range(0, 11)]);
         end else if (kind < 19) begin
            n = $urandom_range(2, 10);
            for (int k = 0; k < n; k++) queue_char(1'b0, 8'($urandom_range(0, 255)));
         end
         // An expression now and then runs on into the next one.
         if ($urandom_range(0, 24) != 0) queue_char(1'b1, 8'($urandom_range(0, 255)));
      end
   endfunction

   // Sender: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      logic accepted;
      logic present;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         accepted = req_tvalid && req_tready;
         if (accepted) begin
            void'(char_backlog.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (!(req_tvalid && !req_tready)) begin
            present = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (char_backlog.size() > 0) begin
               // A settling item waits until every pending result has arrived.
               present = !char_backlog[0].settle || (!accepted && postfix_due.size() == 0);
            end
            if (present) begin
               req_tvalid <= 1'b1;
               req_tdata <= char_backlog[0].ch;
               req_tuser <= char_backlog[0].is_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready follows a stall pattern that changes every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_left = 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 150);
         end else begin
            rx_left--;
         end
         beat++;
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
            default:   rsp_tready <= ((beat % 5) < 2);
         endcase
      end
   end

   // Monitor: predicts on each input transfer, then checks each result transfer.
   always @(posedge clock) begin
      postfix_byte_type want;
      if (reset) begin
         op_depth = 0;
         number_open = 0;
         paren_error = 0;
      end else begin
         if (req_tvalid && req_tready) predict_postfix(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (postfix_due.size() == 0) begin
               $error("result with none expected: out_byte %02h, tuser %b, last %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               faults++;
            end else begin
               want = postfix_due.pop_front();
               if (rsp_tdata !== want.text) begin
                  $error("out_byte mismatch: expected %02h, actual %02h", want.text, rsp_tdata);
                  faults++;
               end
               if (rsp_tuser[0] !== want.text_valid) begin
                  $error("byte_valid mismatch: expected %b, actual %b",
                         want.text_valid, rsp_tuser[0]);
                  faults++;
               end
               if (rsp_tlast !== want.item_last) begin
                  $error("last mismatch: expected %b, actual %b", want.item_last, rsp_tlast);
                  faults++;
               end
               if (rsp_tuser[1] !== want.err) begin
                  $error("error mismatch: expected %b, actual %b", want.err, rsp_tuser[1]);
                  faults++;
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      // Directed: every operator, digit and byte extremes, unmatched ')' and leftover '('.
      queue_text("3.5+9*(0-2)^2^1/4");
      queue_char(1'b1, 8'hFF);
      queue_text("2)");
      queue_char(1'b1, 8'h00);
      queue_text("(7");
      queue_char(1'b0, 8'hFF);
      queue_char(1'b0, 8'h00);
      queue_char(1'b1, 8'hA5);
      settle_next = 1;
      build_random();

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (char_backlog.size() != 0 || req_tvalid || postfix_due.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (faults == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule
